// File: design/ksg_pkg.sv
package ksg_pkg;

    localparam int KSG_GRID_DIM   = 256;
    localparam int KSG_KERNEL_MAX = 64;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_MODE = 8'd3;

    typedef enum logic [1:0] {
        FUNC_SPLAT = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef struct packed {
        t_func              func;
        logic signed [15:0] centre_x;
        logic signed [15:0] centre_y;
        logic [15:0]        splat_weight;
        logic [15:0]        cell_index;
        logic [31:0]        cell_value;
    } t_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic [12:0] taps_applied;
        logic        saturated;
    } t_out;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_MOD,
        OP_WR,
        OP_RD,
        OP_RDCAP,
        OP_ROW_SKIP,
        OP_ADV,
        OP_TAP_FAR,
        OP_TAP_START,
        OP_SQ1,
        OP_SQ2,
        OP_H1,
        OP_H2,
        OP_H3,
        OP_P,
        OP_RMW,
        OP_PUSH
    } t_op;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_MOD,
        S_WR,
        S_RD,
        S_RDCAP,
        S_ROW,
        S_COL,
        S_SQ1,
        S_SQ2,
        S_H1,
        S_H2,
        S_H3,
        S_P,
        S_RMW,
        S_FIN
    } t_state;

    typedef struct packed {
        logic  clr_last;
        t_func func;
        logic  k_zero;
        logic  row_ok;
        logic  row_last;
        logic  col_ok;
        logic  col_last;
        logic  far;
        logic  bit_last;
        logic  out_free;
    } t_stat;

endpackage

// File: design/ksg_ctrl.sv
module ksg_ctrl
    import ksg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_op   o_op
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_stat.func)
                    FUNC_SPLAT: n_state = i_stat.k_zero ? S_FIN : S_ROW;
                    FUNC_WRITE: n_state = S_MOD;
                    FUNC_READ:  n_state = S_MOD;
                    default:    n_state = S_FIN;
                endcase
            end
            S_MOD: begin
                if (i_stat.bit_last) begin
                    n_state = (i_stat.func == FUNC_WRITE) ? S_WR : S_RD;
                end
            end
            S_WR:    n_state = S_FIN;
            S_RD:    n_state = S_RDCAP;
            S_RDCAP: n_state = S_FIN;
            S_ROW: begin
                if (i_stat.row_ok) begin
                    n_state = S_COL;
                end else if (i_stat.row_last) begin
                    n_state = S_FIN;
                end
            end
            S_COL: begin
                if (i_stat.col_ok && !i_stat.far) begin
                    n_state = S_SQ1;
                end else if (i_stat.col_last) begin
                    n_state = i_stat.row_last ? S_FIN : S_ROW;
                end
            end
            S_SQ1: n_state = S_SQ2;
            S_SQ2: n_state = i_stat.bit_last ? S_H1 : S_SQ1;
            S_H1:  n_state = S_H2;
            S_H2:  n_state = S_H3;
            S_H3:  n_state = S_P;
            S_P:   n_state = S_RMW;
            S_RMW: begin
                if (i_stat.col_last) begin
                    n_state = i_stat.row_last ? S_FIN : S_ROW;
                end else begin
                    n_state = S_COL;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // datapath command
    always_comb begin
        o_op    = OP_NONE;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: o_op = OP_CLR;
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_op = OP_LOAD;
            end
            S_MOD:   o_op = OP_MOD;
            S_WR:    o_op = OP_WR;
            S_RD:    o_op = OP_RD;
            S_RDCAP: o_op = OP_RDCAP;
            S_ROW: begin
                if (!i_stat.row_ok) o_op = OP_ROW_SKIP;
            end
            S_COL: begin
                if (!i_stat.col_ok) begin
                    o_op = OP_ADV;
                end else if (i_stat.far) begin
                    o_op = OP_TAP_FAR;
                end else begin
                    o_op = OP_TAP_START;
                end
            end
            S_SQ1: o_op = OP_SQ1;
            S_SQ2: o_op = OP_SQ2;
            S_H1:  o_op = OP_H1;
            S_H2:  o_op = OP_H2;
            S_H3:  o_op = OP_H3;
            S_P:   o_op = OP_P;
            S_RMW: o_op = OP_RMW;
            S_FIN: begin
                if (i_stat.out_free) o_op = OP_PUSH;
            end
            default: o_op = OP_NONE;
        endcase
    end

endmodule

// File: design/ksg_dp.sv
module ksg_dp
    import ksg_pkg::*;
#(
    parameter int GRID_DIM   = KSG_GRID_DIM,
    parameter int KERNEL_MAX = KSG_KERNEL_MAX
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_op                   i_op,
    input  t_in                   i_data,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_ready,
    output logic                  o_valid,
    output t_out                  o_data,
    output t_stat                 o_stat
);

    localparam int CELL_COUNT = GRID_DIM * GRID_DIM;
    localparam int AW  = $clog2(CELL_COUNT);
    localparam int GDW = $clog2(GRID_DIM + 1);
    localparam int KW  = $clog2(KERNEL_MAX + 1);
    localparam int SW  = 2 * KW + 3;
    localparam int TW  = 16 + KW;
    localparam int CW  = SW + 32;
    localparam longint unsigned RECIP = (64'd1 << 32) / 64'(CELL_COUNT);

    // configuration
    logic [8:0] r_gw;
    logic [8:0] r_gh;
    logic [6:0] r_ks;
    logic       r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw   <= 9'd256;
            r_gh   <= 9'd256;
            r_ks   <= 7'd8;
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH:   r_gw   <= i_cfg_data;
                CFG_GRID_HEIGHT:  r_gh   <= i_cfg_data;
                CFG_KERNEL_SIZE:  r_ks   <= i_cfg_data[6:0];
                CFG_COMBINE_MODE: r_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [GDW-1:0] gw_e;
    logic [GDW-1:0] gh_e;
    logic [KW-1:0]  k_e;
    logic [KW-1:0]  half;

    assign gw_e = (int'(r_gw) > GRID_DIM) ? GDW'(GRID_DIM) : GDW'(r_gw);
    assign gh_e = (int'(r_gh) > GRID_DIM) ? GDW'(GRID_DIM) : GDW'(r_gh);
    assign k_e  = (int'(r_ks) > KERNEL_MAX) ? KW'(KERNEL_MAX) : KW'(r_ks);
    assign half = k_e >> 1;

    // item and sequencing registers
    t_in             r_item;
    logic [KW-1:0]   r_i;
    logic [KW-1:0]   r_j;
    logic [3:0]      r_bit;
    logic [15:0]     r_idx;
    logic [15:0]     r_quo;
    logic [AW-1:0]   r_clr;
    logic [AW-1:0]   r_addr;
    logic [SW-1:0]   r_s;
    logic [15:0]     r_u;
    logic [TW-1:0]   r_t;
    logic [33:0]     r_m1;
    logic [51:0]     r_m2;
    logic [16:0]     r_h;
    logic [25:0]     r_p;
    logic [31:0]     r_q;
    logic [31:0]     r_rdata;
    logic [12:0]     r_taps;
    logic            r_sat;
    logic            r_ovalid;
    t_out            r_out;

    // tap geometry
    logic signed [17:0]     row;
    logic signed [17:0]     col;
    logic                   row_ok;
    logic                   col_ok;
    logic                   row_last;
    logic                   col_last;
    logic [AW-1:0]          tap_addr;
    logic signed [KW+1:0]   a;
    logic signed [KW+1:0]   b;
    logic signed [2*KW+3:0] aa;
    logic signed [2*KW+3:0] bb;
    logic [SW-1:0]          s_c;
    logic [2*KW-1:0]        k2;
    logic                   far;

    assign row = 18'(r_item.centre_y) - signed'(18'(half)) + signed'(18'(r_i));
    assign col = 18'(r_item.centre_x) - signed'(18'(half)) + signed'(18'(r_j));
    assign row_ok = (row >= 18'sd0) && (row < signed'(18'(gh_e)));
    assign col_ok = (col >= 18'sd0) && (col < signed'(18'(gw_e)));
    assign row_last = (r_i == KW'(k_e - 1'b1));
    assign col_last = (r_j == KW'(k_e - 1'b1));
    assign tap_addr = AW'(32'(unsigned'(row)) * 32'(GRID_DIM) + 32'(unsigned'(col)));

    assign a   = $signed({1'b0, r_j, 1'b0}) - $signed({2'b00, k_e});
    assign b   = $signed({1'b0, r_i, 1'b0}) - $signed({2'b00, k_e});
    assign aa  = a * a;
    assign bb  = b * b;
    assign s_c = SW'(unsigned'(aa)) + SW'(unsigned'(bb));
    assign k2  = k_e * k_e;
    assign far = (s_c >= SW'(k2));

    // square root search and falloff
    logic [15:0]     cand;
    logic [2*TW-1:0] tt;
    logic [16:0]     om;
    logic [17:0]     f;
    logic [52:0]     h_sum;
    logic [33:0]     pw;
    logic [32:0]     sum;
    logic [47:0]     quo_prod;
    logic [39:0]     quo_back;

    assign cand  = r_u | (16'd1 << r_bit);
    assign tt    = r_t * r_t;
    assign om    = 17'h10000 - 17'(r_u);
    assign f     = 18'h10000 + {1'b0, r_u, 1'b0};
    assign h_sum = 53'(r_m2) + 53'h80000000;
    assign pw    = 34'(r_h) * 34'(r_item.splat_weight) + 34'd128;
    assign sum   = {1'b0, r_q} + 33'(r_p);
    assign quo_prod = 48'(r_idx) * 48'(RECIP);
    assign quo_back = 40'(r_quo) * 40'(CELL_COUNT);

    // memory ports
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic          rd_en;
    logic [AW-1:0] raddr;
    logic [31:0]   rmw_val;
    logic          rmw_sat;

    always_comb begin
        rmw_sat = 1'b0;
        if (r_mode) begin
            rmw_val = (32'(r_p) > r_q) ? 32'(r_p) : r_q;
        end else if (sum[32]) begin
            rmw_val = 32'hFFFF_FFFF;
            rmw_sat = 1'b1;
        end else begin
            rmw_val = sum[31:0];
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = rmw_val;
        case (i_op)
            OP_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = 32'd0;
            end
            OP_WR: begin
                we    = 1'b1;
                waddr = AW'(r_idx);
                wdata = r_item.cell_value;
            end
            OP_RMW: we = 1'b1;
            default: we = 1'b0;
        endcase
    end

    assign rd_en = (i_op == OP_RD) || (i_op == OP_P);
    assign raddr = (i_op == OP_RD) ? AW'(r_idx) : r_addr;

    logic [31:0] r_mem [CELL_COUNT];

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (rd_en) r_q <= r_mem[raddr];
    end

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_op == OP_CLR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // item work
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_item  <= i_data;
                r_idx   <= i_data.cell_index;
                r_i     <= '0;
                r_j     <= '0;
                r_bit   <= 4'd2;
                r_rdata <= 32'd0;
                r_taps  <= 13'd0;
                r_sat   <= 1'b0;
            end
            OP_MOD: begin
                // estimate the quotient by reciprocal, subtract, then correct once
                case (r_bit)
                    4'd2: r_quo <= quo_prod[47:32];
                    4'd1: r_idx <= r_idx - quo_back[15:0];
                    default: begin
                        if (32'(r_idx) >= 32'(CELL_COUNT)) r_idx <= r_idx - 16'(CELL_COUNT);
                    end
                endcase
                r_bit <= r_bit - 1'b1;
            end
            OP_RDCAP: r_rdata <= r_q;
            OP_ROW_SKIP: begin
                r_i <= r_i + 1'b1;
                r_j <= '0;
            end
            OP_ADV, OP_TAP_FAR: begin
                if (col_last) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
                if (i_op == OP_TAP_FAR) r_taps <= r_taps + 1'b1;
            end
            OP_TAP_START: begin
                r_addr <= tap_addr;
                r_s    <= s_c;
                r_u    <= 16'd0;
                r_bit  <= 4'd15;
            end
            OP_SQ1: r_t <= TW'(cand) * TW'(k_e);
            OP_SQ2: begin
                // keep the bit while (u*K)^2 stays within s * 2^32
                if (CW'(tt) <= {r_s, 32'd0}) r_u <= cand;
                r_bit <= r_bit - 1'b1;
            end
            OP_H1: r_m1 <= om * om;
            OP_H2: r_m2 <= 52'(r_m1) * 52'(f);
            OP_H3: r_h  <= h_sum[48:32];
            OP_P:  r_p  <= pw[33:8];
            OP_RMW: begin
                if (rmw_sat) r_sat <= 1'b1;
                r_taps <= r_taps + 1'b1;
                if (col_last) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_op == OP_PUSH) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_PUSH) begin
            r_out.read_data    <= r_rdata;
            r_out.taps_applied <= r_taps;
            r_out.saturated    <= r_sat;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    assign o_stat.clr_last = (r_clr == AW'(CELL_COUNT - 1));
    assign o_stat.func     = r_item.func;
    assign o_stat.k_zero   = (k_e == '0);
    assign o_stat.row_ok   = row_ok;
    assign o_stat.row_last = row_last;
    assign o_stat.col_ok   = col_ok;
    assign o_stat.col_last = col_last;
    assign o_stat.far      = far;
    assign o_stat.bit_last = (r_bit == 4'd0);
    assign o_stat.out_free = !r_ovalid || i_ready;

endmodule

// File: design/kernel_splat_onto_grid.sv
// channel   direction  handshake                  payload
// input     in         i_valid / o_ready          i_data (t_in)
// result    out        o_valid / i_ready          o_data (t_out)
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// After reset a sweep clears all GRID_DIM*GRID_DIM cells of the cell memory (65536 by
// default) before the first request is taken; config writes are taken throughout.
// Cell write and read first reduce the address in three reciprocal steps (estimate, subtract, correct).
// A splat walks the kernel rows and, in rows inside the grid, their columns; each tap
// inside the grid and the kernel radius gets a square root search, falloff and read-modify-write.
// A finished result waits in the output register; the next request is taken meanwhile.
module kernel_splat_onto_grid
    import ksg_pkg::*;
#(
    parameter int GRID_DIM   = KSG_GRID_DIM,
    parameter int KERNEL_MAX = KSG_KERNEL_MAX
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in                   i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out                  o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_op   op;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    ksg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_op    (op)
    );

    ksg_dp #(
        .GRID_DIM   (GRID_DIM),
        .KERNEL_MAX (KERNEL_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_data      (i_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .o_stat      (stat)
    );

endmodule

// File: test/tb_kernel_splat_onto_grid.sv
`timescale 1ns / 100ps

module tb_kernel_splat_onto_grid;
    import ksg_pkg::*;

    localparam int WATCHDOG_LIMIT = 600000;
    localparam int CELLS = KSG_GRID_DIM * KSG_GRID_DIM;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  o_ready;
    t_in                   in_data;
    logic                  o_valid;
    logic                  out_ready;
    t_out                  o_data;
    logic                  cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kernel_splat_onto_grid u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .o_ready     (o_ready),
        .i_data      (in_data),
        .o_valid     (o_valid),
        .i_ready     (out_ready),
        .o_data      (o_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // shadow of the block's state and registers
    bit [31:0] grid_mem [CELLS];
    bit [8:0]  grid_w;
    bit [8:0]  grid_h;
    bit [6:0]  ksize;
    bit        max_mode;

    t_in  pending_reqs[$];
    t_out expected_results[$];
    int   errors;
    int   results_seen;
    int   idle_cycles;
    bit   quiet;
    int   in_gap;
    int   out_stall;
    int   hold_left;
    bit   hold_done;

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned falloff(int k, int i, int j);
        longint a;
        longint b;
        longint unsigned s;
        longint unsigned k2;
        longint unsigned u;
        longint unsigned om;
        a = 2 * j - k;
        b = 2 * i - k;
        s = a * a + b * b;
        k2 = k * k;
        if (s >= k2) u = 65536;
        else u = isqrt((s << 32) / k2);
        om = 65536 - u;
        return (om * om * (65536 + 2 * u) + (64'd1 << 31)) >> 32;
    endfunction

    task automatic predict_request(input t_in r);
        t_out e;
        int gw;
        int gh;
        int k;
        int half;
        int row;
        int col;
        int taps;
        int addr;
        longint unsigned p;
        longint unsigned sum;
        e = '0;
        taps = 0;
        case (r.func)
            FUNC_SPLAT: begin
                gw = grid_w > KSG_GRID_DIM ? KSG_GRID_DIM : grid_w;
                gh = grid_h > KSG_GRID_DIM ? KSG_GRID_DIM : grid_h;
                k = ksize > KSG_KERNEL_MAX ? KSG_KERNEL_MAX : ksize;
                half = k / 2;
                for (int i = 0; i < k; i++) begin
                    row = int'(r.centre_y) - half + i;
                    if (row < 0 || row >= gh) continue;
                    for (int j = 0; j < k; j++) begin
                        col = int'(r.centre_x) - half + j;
                        if (col < 0 || col >= gw) continue;
                        addr = row * KSG_GRID_DIM + col;
                        p = (falloff(k, i, j) * r.splat_weight + 128) >> 8;
                        if (!max_mode) begin
                            sum = grid_mem[addr] + p;
                            if (sum > 64'hFFFF_FFFF) begin
                                sum = 64'hFFFF_FFFF;
                                e.saturated = 1'b1;
                            end
                            grid_mem[addr] = sum[31:0];
                        end else if (p > grid_mem[addr]) begin
                            grid_mem[addr] = p[31:0];
                        end
                        taps++;
                    end
                end
                e.taps_applied = taps[12:0];
            end
            FUNC_WRITE: grid_mem[r.cell_index] = r.cell_value;
            FUNC_READ:  e.read_data = grid_mem[r.cell_index];
            default: ;
        endcase
        expected_results.push_back(e);
    endtask

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        logic took;
        took = in_valid && o_ready;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else begin
            if (took) predict_request(in_data);
            if (!in_valid || took) begin
                if (in_gap > 0) begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    in_data  <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 5);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_stall <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else begin
            if (o_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    e = expected_results.pop_front();
                    if (o_data.read_data !== e.read_data)
                        report($sformatf("read_data %h, want %h", o_data.read_data, e.read_data));
                    if (o_data.taps_applied !== e.taps_applied)
                        report($sformatf("taps_applied %0d, want %0d",
                                         o_data.taps_applied, e.taps_applied));
                    if (o_data.saturated !== e.saturated)
                        report($sformatf("saturated %b, want %b", o_data.saturated, e.saturated));
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (!hold_done && results_seen >= 100) begin
                // long hold-off: let the block back up into its input
                hold_left <= 3000;
                hold_done <= 1'b1;
                out_ready <= 1'b0;
            end else if (out_stall > 0) begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_stall <= $urandom_range(0, 4);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_ready) || (o_valid && out_ready)
            || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GRID_WIDTH:   grid_w   = value[8:0];
            CFG_GRID_HEIGHT:  grid_h   = value[8:0];
            CFG_KERNEL_SIZE:  ksize    = value[6:0];
            CFG_COMBINE_MODE: max_mode = value[0];
            default: ;
        endcase
    endtask

    // sample after the edge has settled so the driver and monitor updates are seen
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic set_grid(input int gw, input int gh, input int k, input int mode);
        wait_idle();
        cfg_write(CFG_GRID_WIDTH, gw);
        cfg_write(CFG_GRID_HEIGHT, gh);
        cfg_write(CFG_KERNEL_SIZE, k);
        cfg_write(CFG_COMBINE_MODE, mode);
    endtask

    function automatic t_in noise();
        t_in r;
        r.func         = t_func'($urandom_range(0, 3));
        r.centre_x     = 16'($urandom);
        r.centre_y     = 16'($urandom);
        r.splat_weight = 16'($urandom);
        r.cell_index   = 16'($urandom);
        r.cell_value   = $urandom;
        return r;
    endfunction

    task automatic add_splat(input int x, input int y, input int w);
        t_in r;
        r = noise();
        r.func = FUNC_SPLAT;
        r.centre_x = x[15:0];
        r.centre_y = y[15:0];
        r.splat_weight = w[15:0];
        pending_reqs.push_back(r);
    endtask

    task automatic add_cell(input t_func f, input int idx, input logic [31:0] value);
        t_in r;
        r = noise();
        r.func = f;
        r.cell_index = idx[15:0];
        r.cell_value = value;
        pending_reqs.push_back(r);
    endtask

    function automatic t_in random_request();
        t_in r;
        int pick;
        r = noise();
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
            r.func = FUNC_SPLAT;
            if ($urandom_range(0, 9) != 0) begin
                r.centre_x = 16'($urandom_range(0, 24)) - 16'sd2;
                r.centre_y = 16'($urandom_range(0, 24)) - 16'sd2;
            end
        end else begin
            r.func = pick < 13 ? FUNC_WRITE : pick < 19 ? FUNC_READ : FUNC_NONE;
            if ($urandom_range(0, 7) != 0)
                r.cell_index = 16'($urandom_range(0, 21) * KSG_GRID_DIM + $urandom_range(0, 21));
            // near-full cells make saturation likely
            if ($urandom_range(0, 1) != 0) r.cell_value[31:20] = 12'hFFF;
        end
        return r;
    endfunction

    function automatic int random_dim();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return KSG_GRID_DIM;
        if (pick < 9) return $urandom_range(1, 30);
        return $urandom_range(257, 511);
    endfunction

    initial begin
        i_clk     = 1'b0;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors       = 0;
        results_seen = 0;
        idle_cycles  = 0;
        quiet        = 1'b0;
        grid_w   = 9'd256;
        grid_h   = 9'd256;
        ksize    = 7'd8;
        max_mode = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_grid(256, 256, 5, 0);
        add_splat(0, 0, 16'h0100);
        add_splat(255, 255, 16'hFFFF);
        add_splat(-32768, 32767, 16'hFFFF);
        add_splat(32767, -32768, 16'h0001);
        add_splat(10, 10, 16'h0000);
        add_cell(FUNC_WRITE, 16'hFFFF, 32'h0000_0000);
        add_cell(FUNC_READ, 16'hFFFF, '0);
        add_cell(FUNC_WRITE, 0, 32'hFFFF_FFFF);
        add_cell(FUNC_READ, 0, '0);
        add_splat(0, 0, 16'hFFFF);
        add_cell(FUNC_READ, 0, '0);
        add_cell(FUNC_READ, 1, '0);
        add_cell(FUNC_WRITE, 16'h0101, 32'h0000_007F);
        add_cell(FUNC_NONE, 16'h0101, 32'h1234_5678);
        add_cell(FUNC_READ, 16'h0101, '0);

        set_grid(256, 256, 5, 1);
        add_splat(1, 1, 16'hFFFF);
        add_cell(FUNC_READ, 16'h0101, '0);
        add_cell(FUNC_READ, 0, '0);

        // empty grid, empty kernel and a one-cell grid
        set_grid(0, 256, 5, 0);
        add_splat(3, 3, 16'h0800);
        set_grid(256, 256, 0, 0);
        add_splat(3, 3, 16'h0800);
        set_grid(1, 1, 1, 0);
        add_splat(0, 0, 16'h0200);
        add_splat(1, 0, 16'h0200);
        add_cell(FUNC_READ, 0, '0);
        // oversized settings act as the limits
        set_grid(511, 511, 127, 1);
        add_splat(-20, -20, 16'h4000);
        set_grid(256, 256, 64, 0);
        add_splat(100, 100, 16'h0180);

        for (int ph = 0; ph < 8; ph++) begin
            set_grid(random_dim(), random_dim(),
                     $urandom_range(0, 9) == 0 ? $urandom_range(9, 12) : $urandom_range(1, 8),
                     $urandom_range(0, 1));
            if (ph == 7) quiet = 1'b1;
            repeat (100) pending_reqs.push_back(random_request());
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/ksg_pkg.sv
design/ksg_ctrl.sv
design/ksg_dp.sv
design/kernel_splat_onto_grid.sv
test/tb_kernel_splat_onto_grid.sv
